@@ rtl/icp_pkg.sv @@
// Shared types and constants for the IPv4 CIDR text parser.
// No dependencies; imported by every module of the block.
package icp_pkg;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int         DECIMAL_BASE  = 10;
    localparam int         FIELD_MAX     = 255;
    localparam int         PREFIX_MAX    = 32;
    localparam logic [2:0] FIELD_COUNT   = 3'd4;
    localparam logic [5:0] NO_PREFIX_LEN = 6'd32;

    typedef enum logic [3:0] {
        ST_OK                = 4'd0,
        ST_EMPTY_FIELD       = 4'd1,
        ST_TOO_MANY          = 4'd2,
        ST_LEADING_ZERO      = 4'd3,
        ST_FIELD_BIG         = 4'd4,
        ST_BAD_CHAR          = 4'd5,
        ST_TOO_FEW           = 4'd6,
        ST_PFX_LEADING_ZERO  = 4'd7,
        ST_PFX_BIG           = 4'd8,
        ST_PFX_MISSING       = 4'd9
    } t_status;

    typedef struct packed {
        logic        in_prefix;
        logic [2:0]  fields_done;
        logic [7:0]  field_value;
        logic        digit_seen;
        logic [31:0] address_bits;
        logic [5:0]  prefix_value;
        t_status     first_error;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        in_prefix:    1'b0,
        fields_done:  3'd0,
        field_value:  8'd0,
        digit_seen:   1'b0,
        address_bits: 32'd0,
        prefix_value: 6'd0,
        first_error:  ST_OK
    };

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_char_item;

    typedef struct packed {
        logic [31:0] address;
        logic [5:0]  prefix_length;
        t_status     status;
    } t_result;

endpackage

@@ rtl/ipv4_cidr_text_parser_unit.sv @@
// IPv4 CIDR text parser: one ASCII character per item, result on the last one.
// A last character passes the input register and parse step into the result register.
// Throughput: one character per cycle; a last one waits on a full, undrained result register.
// Reset (i_rst_n low, synchronous) clears the parse state and both valid flags.
// Depends on icp_pkg, icp_in_stage and icp_char_step.
module ipv4_cidr_text_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_address,
    output logic [5:0]  o_prefix_length,
    output logic [3:0]  o_status
);
    import icp_pkg::*;

    // Parse state: phase, field count, field/prefix accumulators, first error.
    t_parse_state r_state;
    t_parse_state n_state;

    // Result register, parts the step logic from the consumer.
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;

    t_char_item w_in_item;
    t_char_item w_cur_item;
    logic       w_cur_valid;
    logic       w_advance;

    assign w_in_item.character = i_character;
    assign w_in_item.last      = i_last;

    icp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_in_item),
        .i_take  (w_advance),
        .o_valid (w_cur_valid),
        .o_item  (w_cur_item)
    );

    icp_char_step u_char_step (
        .i_state      (r_state),
        .i_item       (w_cur_item),
        .o_next_state (n_state),
        .o_result     (w_result)
    );

    // A non-last character never produces a result, so it always moves on.
    // A last character needs the result register free or draining this cycle.
    assign w_advance = w_cur_valid && (!w_cur_item.last || !r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_cur_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_cur_item.last) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_address       = r_out.address;
    assign o_prefix_length = r_out.prefix_length;
    assign o_status        = 4'(r_out.status);

`ifndef SYNTHESIS
    // Error results carry zero address and prefix.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != 4'(ST_OK)) |-> (o_address == 32'd0 && o_prefix_length == 6'd0))
        else $error("error result with nonzero payload");

    // A good result never has a prefix beyond 32.
    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == 4'(ST_OK)) |-> (o_prefix_length <= NO_PREFIX_LEN))
        else $error("prefix length out of range");

    // The parse state returns to reset after a last character is consumed.
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_cur_item.last) |=> (r_state == PARSE_RESET))
        else $error("parse state not cleared after last character");

    // A new result appears only after a last character went through the step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_advance && w_cur_item.last))
        else $error("result without a last character");
`endif

endmodule

@@ rtl/icp_in_stage.sv @@
// Input register of the parser: holds one character item for the step logic.
// Depends on icp_pkg.
module icp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  icp_pkg::t_char_item i_item,
    input  logic               i_take,
    output logic               o_valid,
    output icp_pkg::t_char_item o_item
);
    import icp_pkg::*;

    logic       r_valid;
    t_char_item r_item;
    logic       w_load;

    // Free when empty or when the held item moves on this cycle.
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/icp_char_step.sv @@
// Per-character parse step: next parse state and the result of a last item.
// Purely combinational; depends on icp_pkg.
module icp_char_step (
    input  icp_pkg::t_parse_state i_state,
    input  icp_pkg::t_char_item   i_item,
    output icp_pkg::t_parse_state o_next_state,
    output icp_pkg::t_result      o_result
);
    import icp_pkg::*;

    function automatic t_parse_state close_field(t_parse_state st);
        t_parse_state r;
        r = st;
        if (!st.digit_seen) begin
            r.first_error = ST_EMPTY_FIELD;
        end else if (st.fields_done >= FIELD_COUNT) begin
            r.first_error = ST_TOO_MANY;
        end else begin
            r.address_bits = {st.address_bits[23:0], st.field_value};
            r.fields_done  = st.fields_done + 3'd1;
            r.field_value  = 8'd0;
            r.digit_seen   = 1'b0;
        end
        return r;
    endfunction

    function automatic t_parse_state close_address(t_parse_state st);
        t_parse_state r;
        r = close_field(st);
        if (r.first_error == ST_OK && r.fields_done < FIELD_COUNT) begin
            r.first_error = ST_TOO_FEW;
        end
        return r;
    endfunction

    t_parse_state s;
    logic         w_is_digit;
    logic [3:0]   w_digit;
    logic [11:0]  w_field_acc;
    logic [8:0]   w_prefix_acc;
    logic [5:0]   w_plen;

    // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value.
    assign w_is_digit   = (i_item.character >= CHAR_ZERO) && (i_item.character <= CHAR_NINE);
    assign w_digit      = i_item.character[3:0];
    assign w_field_acc  = 12'(i_state.field_value) * 12'(DECIMAL_BASE) + {8'd0, w_digit};
    assign w_prefix_acc = 9'(i_state.prefix_value) * 9'(DECIMAL_BASE) + {5'd0, w_digit};

    always_comb begin
        s      = i_state;
        w_plen = NO_PREFIX_LEN;
        if (s.first_error == ST_OK) begin
            if (!s.in_prefix) begin
                if (i_item.character == CHAR_DOT) begin
                    s = close_field(s);
                end else if (w_is_digit) begin
                    if (s.digit_seen && s.field_value == 8'd0) begin
                        s.first_error = ST_LEADING_ZERO;
                    end else begin
                        s.digit_seen = 1'b1;
                        if (w_field_acc > 12'(FIELD_MAX)) begin
                            s.first_error = ST_FIELD_BIG;
                        end else begin
                            s.field_value = w_field_acc[7:0];
                        end
                    end
                end else if (i_item.character == CHAR_SLASH) begin
                    s = close_address(s);
                    if (s.first_error == ST_OK) begin
                        s.in_prefix    = 1'b1;
                        s.digit_seen   = 1'b0;
                        s.prefix_value = 6'd0;
                    end
                end else begin
                    s.first_error = ST_BAD_CHAR;
                end
            end else begin
                if (w_is_digit) begin
                    if (s.digit_seen && s.prefix_value == 6'd0) begin
                        s.first_error = ST_PFX_LEADING_ZERO;
                    end else begin
                        s.digit_seen = 1'b1;
                        if (w_prefix_acc > 9'(PREFIX_MAX)) begin
                            s.first_error = ST_PFX_BIG;
                        end else begin
                            s.prefix_value = w_prefix_acc[5:0];
                        end
                    end
                end else begin
                    s.first_error = ST_BAD_CHAR;
                end
            end
        end

        // End of text: finish the open part.
        if (i_item.last && s.first_error == ST_OK) begin
            if (!s.in_prefix) begin
                s = close_address(s);
            end else if (!s.digit_seen) begin
                s.first_error = ST_PFX_MISSING;
            end else begin
                w_plen = s.prefix_value;
            end
        end

        o_result.status = s.first_error;
        if (s.first_error == ST_OK) begin
            o_result.address       = s.address_bits;
            o_result.prefix_length = w_plen;
        end else begin
            o_result.address       = 32'd0;
            o_result.prefix_length = 6'd0;
        end

        o_next_state = i_item.last ? PARSE_RESET : s;
    end

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for ipv4_cidr_text_parser_unit: netblock text in, one result per string.
// Depends on icp_pkg (status codes, character constants, result type) and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
    import icp_pkg::*;

    // Run shape
    localparam int RANDOM_CHARS = 1456;   // characters in the random part
    localparam int QUIET_TAIL   = 250;    // last characters sent with no idling
    localparam int LONG_HOLD    = 300;    // one long result-side stall, in cycles
    localparam int DRAIN_CYCLES = 10;     // slack after the last result is taken
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_character;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_address;
    logic [5:0]  o_prefix_length;
    logic [3:0]  o_status;

    ipv4_cidr_text_parser_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_character     (i_character),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_address       (o_address),
        .o_prefix_length (o_prefix_length),
        .o_status        (o_status)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parse model: mirrors the block's state, one character at a time.
    // ------------------------------------------------------------------
    logic        p_in_prefix;
    logic [2:0]  p_fields;
    logic [7:0]  p_field;
    logic        p_digit;
    logic [31:0] p_addr;
    logic [5:0]  p_pfx;
    t_status     p_err;

    function automatic void clear_parse();
        p_in_prefix = 1'b0;
        p_fields    = 3'd0;
        p_field     = 8'd0;
        p_digit     = 1'b0;
        p_addr      = 32'd0;
        p_pfx       = 6'd0;
        p_err       = ST_OK;
    endfunction

    // Only the first error sticks
    function automatic void latch_error(t_status code);
        if (p_err == ST_OK) begin
            p_err = code;
        end
    endfunction

    // Closes one dotted field; 0 when an error was raised
    function automatic bit close_field();
        if (!p_digit) begin
            latch_error(ST_EMPTY_FIELD);
            return 1'b0;
        end
        if (p_fields >= FIELD_COUNT) begin
            latch_error(ST_TOO_MANY);
            return 1'b0;
        end
        p_addr   = {p_addr[23:0], p_field};
        p_fields = p_fields + 3'd1;
        p_field  = 8'd0;
        p_digit  = 1'b0;
        return 1'b1;
    endfunction

    // End of the address part: last field plus the four-field count
    function automatic void close_address();
        if (close_field()) begin
            if (p_fields < FIELD_COUNT) begin
                latch_error(ST_TOO_FEW);
            end
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        bit is_digit;
        int acc;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        acc      = 0;
        if (!p_in_prefix) begin
            if (c == CHAR_DOT) begin
                void'(close_field());
            end else if (is_digit) begin
                if (p_digit && p_field == 8'd0) begin
                    latch_error(ST_LEADING_ZERO);
                end else begin
                    acc     = int'(p_field) * DECIMAL_BASE + int'(c - CHAR_ZERO);
                    p_digit = 1'b1;
                    if (acc > FIELD_MAX) begin
                        latch_error(ST_FIELD_BIG);
                    end else begin
                        p_field = acc[7:0];
                    end
                end
            end else if (c == CHAR_SLASH) begin
                close_address();
                if (p_err == ST_OK) begin
                    p_in_prefix = 1'b1;
                    p_digit     = 1'b0;
                    p_pfx       = 6'd0;
                end
            end else begin
                latch_error(ST_BAD_CHAR);
            end
        end else begin
            // prefix phase: digits only, a second slash or a dot is invalid
            if (is_digit) begin
                if (p_digit && p_pfx == 6'd0) begin
                    latch_error(ST_PFX_LEADING_ZERO);
                end else begin
                    acc     = int'(p_pfx) * DECIMAL_BASE + int'(c - CHAR_ZERO);
                    p_digit = 1'b1;
                    if (acc > PREFIX_MAX) begin
                        latch_error(ST_PFX_BIG);
                    end else begin
                        p_pfx = acc[5:0];
                    end
                end
            end else begin
                latch_error(ST_BAD_CHAR);
            end
        end
    endfunction

    // One accepted character; returns 1 with the result on a last character
    function automatic bit parse_char(logic [7:0] c, logic last, output t_result res);
        logic [5:0] plen;
        plen = NO_PREFIX_LEN;
        res  = '0;
        if (p_err == ST_OK) begin
            take_char(c);
        end
        if (!last) begin
            return 1'b0;
        end
        if (p_err == ST_OK) begin
            if (!p_in_prefix) begin
                close_address();
            end else if (!p_digit) begin
                latch_error(ST_PFX_MISSING);
            end else begin
                plen = p_pfx;
            end
        end
        // error results carry zero address and prefix
        if (p_err == ST_OK) begin
            res.address       = p_addr;
            res.prefix_length = plen;
        end
        res.status = p_err;
        clear_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_result     pending_results[$];   // results owed by the block, oldest first
    logic [7:0]  text_q[$];            // characters of the string being sent
    string       row_text[$];
    bit          row_typed[$];
    t_result     row_res[$];
    int          mismatch_count;
    int          chars_sent;
    int          cycle_count;
    bit          idle_on;
    bit          hold_req;
    t_result     got_want;

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Directed table row; typed rows carry the expected result written out
    task automatic add_row(string text, bit typed, logic [31:0] a, logic [5:0] pl,
                           t_status st);
        row_text.push_back(text);
        row_typed.push_back(typed);
        row_res.push_back('{address: a, prefix_length: pl, status: st});
    endtask

    function automatic void load_text(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    // Send one item. Idle bursts drop valid first; once valid is up it holds
    // until the accepting edge.
    task automatic send_char(logic [7:0] c, logic last, bit typed, t_result typed_res);
        t_result res;
        int      gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= c;
        i_last      <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        chars_sent++;
        if (parse_char(c, last, res)) begin
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send_text(bit typed, t_result typed_res);
        foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1, typed, typed_res);
        end
    endtask

    // ------------------------------------------------------------------
    // Random string pieces
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return CHAR_DOT;
            2:       return CHAR_SLASH;
            default: return CHAR_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic string field_text();
        case ($urandom_range(0, 29))
            0, 1, 2: return "0";
            3, 4, 5: return "255";
            6:       return $sformatf("%0d", $urandom_range(256, 999));
            7:       return $sformatf("0%0d", $urandom_range(0, 99));
            default: return $sformatf("%0d", $urandom_range(0, 255));
        endcase
    endfunction

    function automatic string prefix_text();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: return "";
            6:                return "/";
            7:                return "/0";
            8:                return "/32";
            9:                return $sformatf("/%0d", $urandom_range(33, 99));
            10:               return $sformatf("/0%0d", $urandom_range(0, 9));
            default:          return $sformatf("/%0d", $urandom_range(0, 32));
        endcase
    endfunction

    // Mostly well-formed netblocks with random content, some broken, some noise
    task automatic build_random();
        int    kind;
        int    nfields;
        int    pos;
        string s;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            text_q.delete();
            repeat ($urandom_range(1, 10)) text_q.push_back(pick_char());
        end else begin
            nfields = 4;
            if ($urandom_range(0, 15) == 0) begin
                nfields = $urandom_range(0, 1) ? 3 : 5;
            end
            s = field_text();
            for (int f = 1; f < nfields; f++) begin
                s = {s, ".", field_text()};
            end
            s = {s, prefix_text()};
            load_text(s);
            if (kind >= 8) begin
                pos = $urandom_range(0, text_q.size() - 1);
                case ($urandom_range(0, 2))
                    0:       text_q[pos] = pick_char();
                    1:       text_q.delete(pos);
                    default: text_q.insert(pos, pick_char());
                endcase
                if (text_q.size() == 0) begin
                    text_q.push_back(pick_char());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random part, drain.
    // ------------------------------------------------------------------
    initial begin
        int random_start;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_character    = 8'd0;
        i_last         = 1'b0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        mismatch_count = 0;
        chars_sent     = 0;
        clear_parse();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // good netblocks, some at the extremes
        add_row("0.0.0.0",            1, 32'h0000_0000, 6'd32, ST_OK);
        add_row("255.255.255.255/32", 1, 32'hFFFF_FFFF, 6'd32, ST_OK);
        add_row("1.2.3.4/0",          1, 32'h0102_0304, 6'd0,  ST_OK);
        add_row("10.0.0.1/8",         0, 32'h0, 6'd0, ST_OK);
        add_row("192.168.100.200/24", 0, 32'h0, 6'd0, ST_OK);
        // one row per error code
        add_row("1..2.3",             1, 32'h0, 6'd0, ST_EMPTY_FIELD);
        add_row("1.2.3.4.5",          1, 32'h0, 6'd0, ST_TOO_MANY);
        add_row("01.2.3.4",           1, 32'h0, 6'd0, ST_LEADING_ZERO);
        add_row("256.1.1.1",          1, 32'h0, 6'd0, ST_FIELD_BIG);
        add_row("1.2.3.a",            1, 32'h0, 6'd0, ST_BAD_CHAR);
        add_row("1.2.3",              1, 32'h0, 6'd0, ST_TOO_FEW);
        add_row("1.2.3.4/01",         1, 32'h0, 6'd0, ST_PFX_LEADING_ZERO);
        add_row("1.2.3.4/33",         1, 32'h0, 6'd0, ST_PFX_BIG);
        add_row("1.2.3.4/",           1, 32'h0, 6'd0, ST_PFX_MISSING);
        // slash or dot inside the prefix
        add_row("1.2.3.4//",          1, 32'h0, 6'd0, ST_BAD_CHAR);
        add_row("1.2.3.4/2.4",        1, 32'h0, 6'd0, ST_BAD_CHAR);
        // first error wins over later ones
        add_row("x.256",              1, 32'h0, 6'd0, ST_BAD_CHAR);
        add_row("1.2.3/8",            1, 32'h0, 6'd0, ST_TOO_FEW);
        // single-character strings, a trailing dot, a high byte and an oversized field
        add_row(".",                  1, 32'h0, 6'd0, ST_EMPTY_FIELD);
        add_row("7",                  1, 32'h0, 6'd0, ST_TOO_FEW);
        add_row("/",                  1, 32'h0, 6'd0, ST_EMPTY_FIELD);
        add_row("1.2.3.4.",           1, 32'h0, 6'd0, ST_EMPTY_FIELD);
        add_row("1.2.3.4\377",        1, 32'h0, 6'd0, ST_BAD_CHAR);
        add_row("999.0.0.0",          0, 32'h0, 6'd0, ST_OK);

        foreach (row_text[r]) begin
            load_text(row_text[r]);
            send_text(row_typed[r], row_res[r]);
        end

        // random part opens with the long result-side stall so the block backs up
        random_start = chars_sent;
        hold_req     = 1'b1;
        while (chars_sent < random_start + RANDOM_CHARS) begin
            if (chars_sent >= random_start + RANDOM_CHARS - QUIET_TAIL) begin
                idle_on = 1'b0;
            end
            build_random();
            send_text(1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ipv4_cidr_text_parser_unit test passed");
        end else begin
            $display("ipv4_cidr_text_parser_unit test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, one long hold counted here.
    // ------------------------------------------------------------------
    initial begin
        int k;
        bit held;
        int gap;
        i_ready = 1'b0;
        held    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare each accepted result with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", {28'd0, o_status}, 32'd0);
            end else begin
                got_want = pending_results.pop_front();
                if (o_address !== got_want.address) begin
                    flag_mismatch("address", o_address, got_want.address);
                end
                if (o_prefix_length !== got_want.prefix_length) begin
                    flag_mismatch("prefix_length", {26'd0, o_prefix_length},
                                  {26'd0, got_want.prefix_length});
                end
                if (o_status !== got_want.status) begin
                    flag_mismatch("status", {28'd0, o_status}, {28'd0, got_want.status});
                end
            end
        end
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ipv4_cidr_text_parser_unit test failed");
            $finish;
        end
    end

endmodule
